FILE: design/lprd_pkg.sv
// Shared types and constants for the length-prefixed request deframer.
package lprd_pkg;

	// Width of the configuration register index (two registers).
	localparam int unsigned CFG_INDEX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MSG_LEN = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARGS    = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [31:0] MAX_MSG_LEN_RESET = 32'd33554432;
	localparam logic [31:0] MAX_ARGS_RESET    = 32'd200000;

	// Every header field is four bytes, little endian.
	localparam logic [31:0] FIELD_BYTES = 32'd4;

	// Byte role codes.
	localparam logic [2:0] ROLE_MSG_LEN   = 3'd0;
	localparam logic [2:0] ROLE_ARG_COUNT = 3'd1;
	localparam logic [2:0] ROLE_ARG_LEN   = 3'd2;
	localparam logic [2:0] ROLE_CONTENT   = 3'd3;
	localparam logic [2:0] ROLE_IGNORED   = 3'd4;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
	localparam logic [2:0] ERR_TOO_MANY  = 3'd2;
	localparam logic [2:0] ERR_OVERRUN   = 3'd3;
	localparam logic [2:0] ERR_LEFTOVER  = 3'd4;

	// Parser phase.
	typedef enum logic [3:0] {
		PH_MSG_LEN   = 4'b0001,
		PH_ARG_COUNT = 4'b0010,
		PH_ARG_LEN   = 4'b0100,
		PH_CONTENT   = 4'b1000
	} phase_t;

	// One input byte of the stream.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_connection;
	} req_t;

	// One classified output byte.
	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_role;
		logic [31:0] arg_index;
		logic [31:0] arg_length;
		logic        arg_end;
		logic        msg_end;
		logic [2:0]  error_code;
	} rsp_t;

endpackage

FILE: design/length_prefixed_request_deframer_core.sv
// Length-prefixed request deframer: one byte per transaction, classified and checked.
// A result is registered: it is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register is reloaded in the
// cycle it is taken, so the input stalls only while a result waits unclaimed.
// Reset: parser state, latched error and output valid clear; the two limit
// registers return to 33554432 bytes and 200000 arguments.
module length_prefixed_request_deframer_core import lprd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  req_t                   req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rsp_t                   rsp,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	// Configuration registers.
	logic [31:0] max_msg_len_q;
	logic [31:0] max_args_q;

	// Parser state.
	phase_t      phase_q;
	logic [1:0]  field_cnt_q;
	logic [31:0] field_shift_q;
	logic [31:0] msg_left_q;
	logic [31:0] args_left_q;
	logic [31:0] arg_left_q;
	logic [31:0] cur_arg_q;
	logic [31:0] ann_len_q;
	logic [2:0]  err_q;

	// Output register.
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// State as seen by the current byte, after an optional connection restart.
	phase_t      ph;
	logic [1:0]  cnt;
	logic [31:0] shift;
	logic [31:0] msg_left;
	logic [31:0] args_left;
	logic [31:0] arg_left;
	logic [31:0] cur_arg;
	logic [31:0] ann_len;
	logic [2:0]  err;

	// Next state and result.
	phase_t      nx_ph;
	logic [1:0]  nx_cnt;
	logic [31:0] nx_shift;
	logic [31:0] nx_msg_left;
	logic [31:0] nx_args_left;
	logic [31:0] nx_arg_left;
	logic [31:0] nx_cur_arg;
	logic [31:0] nx_ann_len;
	logic [2:0]  nx_err;
	logic [31:0] asm_field;
	logic        finish;
	rsp_t        res;

	logic        req_accept;

	assign req_stall  = rsp_valid_q && rsp_stall;
	assign req_accept = req_valid && !req_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// Parse one byte.
	always_comb begin
		ph        = phase_q;
		cnt       = field_cnt_q;
		shift     = field_shift_q;
		msg_left  = msg_left_q;
		args_left = args_left_q;
		arg_left  = arg_left_q;
		cur_arg   = cur_arg_q;
		ann_len   = ann_len_q;
		err       = err_q;
		if (req.new_connection) begin
			ph        = PH_MSG_LEN;
			cnt       = 2'd0;
			shift     = 32'd0;
			msg_left  = 32'd0;
			args_left = 32'd0;
			arg_left  = 32'd0;
			cur_arg   = 32'd0;
			ann_len   = 32'd0;
			err       = ERR_NONE;
		end

		nx_ph        = ph;
		nx_cnt       = cnt;
		nx_shift     = shift;
		nx_msg_left  = msg_left;
		nx_args_left = args_left;
		nx_arg_left  = arg_left;
		nx_cur_arg   = cur_arg;
		nx_ann_len   = ann_len;
		nx_err       = err;
		finish       = 1'b0;
		asm_field    = shift;

		res            = '0;
		res.byte_out   = req.data_byte;
		res.byte_role  = ROLE_IGNORED;

		if (err == ERR_NONE) begin
			if (ph == PH_CONTENT) begin
				// Content byte of the current argument.
				res.byte_role  = ROLE_CONTENT;
				res.arg_index  = cur_arg;
				res.arg_length = ann_len;
				nx_arg_left    = arg_left - 32'd1;
				nx_msg_left    = msg_left - 32'd1;
				if (arg_left == 32'd1) begin
					res.arg_end = 1'b1;
					finish      = 1'b1;
				end
			end else begin
				// Assemble a little-endian header field.
				case (cnt)
					2'd0:    asm_field = shift | {24'd0, req.data_byte};
					2'd1:    asm_field = shift | {16'd0, req.data_byte, 8'd0};
					2'd2:    asm_field = shift | {8'd0, req.data_byte, 16'd0};
					default: asm_field = shift | {req.data_byte, 24'd0};
				endcase
				nx_cnt = cnt + 2'd1;
				if (ph != PH_MSG_LEN) begin
					nx_msg_left = msg_left - 32'd1;
				end
				unique case (ph)
					PH_MSG_LEN:   res.byte_role = ROLE_MSG_LEN;
					PH_ARG_COUNT: res.byte_role = ROLE_ARG_COUNT;
					PH_ARG_LEN: begin
						res.byte_role = ROLE_ARG_LEN;
						res.arg_index = cur_arg;
					end
					default:      res.byte_role = ROLE_IGNORED;
				endcase

				if (cnt == 2'd3) begin
					// Field complete: check and act on it.
					nx_shift = 32'd0;
					unique case (ph)
						PH_MSG_LEN: begin
							if (asm_field > max_msg_len_q) begin
								nx_err = ERR_TOO_LONG;
							end else begin
								nx_msg_left = asm_field;
								if (asm_field < FIELD_BYTES) begin
									nx_err = ERR_OVERRUN;
								end else begin
									nx_ph = PH_ARG_COUNT;
								end
							end
						end
						PH_ARG_COUNT: begin
							if (asm_field > max_args_q) begin
								nx_err = ERR_TOO_MANY;
							end else if (asm_field == 32'd0) begin
								if (nx_msg_left != 32'd0) begin
									nx_err = ERR_LEFTOVER;
								end else begin
									res.msg_end = 1'b1;
									nx_ph       = PH_MSG_LEN;
								end
							end else begin
								nx_args_left = asm_field;
								nx_cur_arg   = 32'd0;
								if (nx_msg_left < FIELD_BYTES) begin
									nx_err = ERR_OVERRUN;
								end else begin
									nx_ph = PH_ARG_LEN;
								end
							end
						end
						default: begin
							nx_ann_len     = asm_field;
							res.arg_length = asm_field;
							if (asm_field > nx_msg_left) begin
								nx_err = ERR_OVERRUN;
							end else if (asm_field == 32'd0) begin
								res.arg_end = 1'b1;
								finish      = 1'b1;
							end else begin
								nx_arg_left = asm_field;
								nx_ph       = PH_CONTENT;
							end
						end
					endcase
				end else begin
					nx_shift = asm_field;
				end
			end

			// Close an argument: next argument, end of message, leftover bytes or overrun.
			if (finish) begin
				nx_args_left = args_left - 32'd1;
				nx_cur_arg   = cur_arg + 32'd1;
				if (args_left == 32'd1) begin
					if (nx_msg_left != 32'd0) begin
						nx_err = ERR_LEFTOVER;
					end else begin
						nx_ph       = PH_MSG_LEN;
						nx_cur_arg  = 32'd0;
						res.msg_end = 1'b1;
					end
				end else if (nx_msg_left < FIELD_BYTES) begin
					nx_err = ERR_OVERRUN;
				end else begin
					nx_ph = PH_ARG_LEN;
				end
			end

			// The byte that raises an error marks no ends.
			if (nx_err != ERR_NONE) begin
				res.arg_end = 1'b0;
				res.msg_end = 1'b0;
			end
		end
		res.error_code = nx_err;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_len_q <= MAX_MSG_LEN_RESET;
			max_args_q    <= MAX_ARGS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_MSG_LEN: max_msg_len_q <= cfg_data;
				CFG_MAX_ARGS:    max_args_q    <= cfg_data;
				default:         max_args_q    <= max_args_q;
			endcase
		end
	end

	// Parser state update on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MSG_LEN;
			field_cnt_q   <= 2'd0;
			field_shift_q <= 32'd0;
			msg_left_q    <= 32'd0;
			args_left_q   <= 32'd0;
			arg_left_q    <= 32'd0;
			cur_arg_q     <= 32'd0;
			ann_len_q     <= 32'd0;
			err_q         <= ERR_NONE;
		end else if (req_accept) begin
			phase_q       <= nx_ph;
			field_cnt_q   <= nx_cnt;
			field_shift_q <= nx_shift;
			msg_left_q    <= nx_msg_left;
			args_left_q   <= nx_args_left;
			arg_left_q    <= nx_arg_left;
			cur_arg_q     <= nx_cur_arg;
			ann_len_q     <= nx_ann_len;
			err_q         <= nx_err;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			rsp_q <= res;
		end
	end

endmodule
